/* rtl/core/pointer_event_reconciler_assert.svh */
// Assertion macros for the pointer event reconciler
`ifndef POINTER_EVENT_RECONCILER_ASSERT_SVH
`define POINTER_EVENT_RECONCILER_ASSERT_SVH

// a consequent must hold in the cycle after the antecedent
`define PER_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// a condition must hold in every cycle outside reset
`define PER_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

`endif

/* rtl/core/per_pkg.sv */
`default_nettype none
package per_pkg;

   localparam int unsigned WindowMsDefault = 1000;
   localparam logic [15:0] DeadmanReset = 16'd1000;
   localparam logic [16:0] CountMax = 17'h1FFFF;
   localparam int unsigned QueueDepth = 2;

   typedef enum logic [2:0] {
      MODE_MOVE = 3'd0, MODE_SCROLL = 3'd1, MODE_PRESS = 3'd2,
      MODE_RELEASE = 3'd3, MODE_TICK = 3'd4, MODE_RESET = 3'd5,
      MODE_RSV6 = 3'd6, MODE_RSV7 = 3'd7
   } mode_type;

   typedef enum logic [2:0] {
      CMD_NONE = 3'd0, CMD_MOVE = 3'd1, CMD_SCROLL = 3'd2,
      CMD_DOWN = 3'd3, CMD_UP = 3'd4
   } cmd_type;

   typedef enum logic [2:0] {
      ST_APPLIED = 3'd0, ST_RATE = 3'd1, ST_STALE = 3'd2,
      ST_STALE_SCROLL = 3'd3, ST_DEADMAN = 3'd4, ST_NOTHING = 3'd5
   } status_type;

   // register indexes of the configuration port
   localparam logic [0:0] REG_MAX_PER_SECOND = 1'b0;
   localparam logic [0:0] REG_DEADMAN_MS = 1'b1;

   typedef struct packed {
      logic [2:0]  mode;
      logic [31:0] seq;
      logic [15:0] pos_x;
      logic [15:0] pos_y;
      logic [1:0]  button;
      logic [2:0]  want_mask;
      logic [3:0]  clicks;
      logic signed [15:0] scroll_dx;
      logic signed [15:0] scroll_dy;
      logic [31:0] now_ms;
   } req_type;

   typedef struct packed {
      logic [2:0]  command;
      logic [1:0]  out_button;
      logic [15:0] out_x;
      logic [15:0] out_y;
      logic [2:0]  held_now;
      logic signed [15:0] out_dx;
      logic signed [15:0] out_dy;
      logic [3:0]  out_clicks;
      logic [2:0]  status;
      logic        repair;
      logic        last;
   } rsp_type;

   // classified work for the back end: an ordered list of up to five commands
   typedef struct packed {
      logic [2:0]  cmd;
      logic [1:0]  btn;
      logic [3:0]  clicks;
      logic [2:0]  status;
      logic        repair;
      logic        scroll;
      logic [2:0]  held;
      logic [31:0] pos;
   } slot_type;

   typedef struct packed {
      logic [2:0] count;
      slot_type [4:0] slots;
      logic signed [15:0] dx;
      logic signed [15:0] dy;
   } work_type;

endpackage
`default_nettype wire

/* rtl/core/per_front.sv */
`default_nettype none
module per_front #(
   parameter int unsigned WINDOW_MS = per_pkg::WindowMsDefault
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [0:0]        csr_index,
   input  wire logic [15:0]       csr_data,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire per_pkg::req_type  req_payload,
   output logic                   wq_valid,
   input  wire logic              wq_full,
   output per_pkg::work_type      wq_data
);
   localparam logic [31:0] WinLimit = 32'(WINDOW_MS);

   logic [15:0] max_ps_ff, deadman_ff;
   logic [2:0]  held_ff, held_in;
   logic        sample_seen_ff, sample_seen_in;
   logic [31:0] newest_ff, newest_in;
   logic [2:0]  bseen_ff, bseen_in;
   logic [31:0] bseq_ff [3];
   logic [31:0] bseq_in [3];
   logic [31:0] pos_ff, pos_in;
   logic [31:0] mtime_ff, mtime_in;
   logic        mvalid_ff, mvalid_in;
   logic [31:0] wstart_ff, wstart_in;
   logic [16:0] wcount_ff, wcount_in;
   per_pkg::work_type w;

   assign csr_ready = 1'b1;
   assign req_stall = wq_full;
   assign wq_valid  = req_valid && !wq_full;
   assign wq_data   = w;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ps_ff <= '0;
         deadman_ff <= per_pkg::DeadmanReset;
      end else if (csr_valid) begin
         if (csr_index == per_pkg::REG_MAX_PER_SECOND) max_ps_ff <= csr_data;
         else deadman_ff <= csr_data;
      end
   end

   always_comb begin
      per_pkg::req_type r;
      logic [2:0] h;
      logic [2:0] bit_m;
      logic [2:0] n;
      logic lim;
      logic [16:0] cnt;
      r = req_payload;
      h = held_ff;
      n = '0;
      lim = 1'b0;
      cnt = wcount_ff;
      held_in = held_ff; sample_seen_in = sample_seen_ff; newest_in = newest_ff;
      bseen_in = bseen_ff; bseq_in = bseq_ff; pos_in = pos_ff;
      mtime_in = mtime_ff; mvalid_in = mvalid_ff;
      wstart_in = wstart_ff; wcount_in = wcount_ff;
      w = '0;
      w.dx = r.scroll_dx; w.dy = r.scroll_dy;
      bit_m = 3'b001 << r.button;

      // build the command list using current held mask and position
      unique case (per_pkg::mode_type'(r.mode))
         per_pkg::MODE_TICK: begin
            if (h == '0 || !mvalid_ff || (r.now_ms - mtime_ff) < {16'd0, deadman_ff}) begin
               w.slots[0] = '{cmd: per_pkg::CMD_NONE, btn: 2'd0, clicks: 4'd0,
                  status: per_pkg::ST_NOTHING, repair: 1'b0, scroll: 1'b0,
                  held: h, pos: pos_ff};
               n = 3'd1;
            end else begin
               for (int i = 0; i < 3; i++) begin
                  if (h[i]) begin
                     h[i] = 1'b0;
                     w.slots[n] = '{cmd: per_pkg::CMD_UP, btn: 2'(i), clicks: 4'd1,
                        status: per_pkg::ST_DEADMAN, repair: 1'b0, scroll: 1'b0,
                        held: h, pos: pos_ff};
                     n = n + 3'd1;
                  end
               end
            end
         end
         per_pkg::MODE_RESET: begin
            if (h == '0) begin
               w.slots[0] = '{cmd: per_pkg::CMD_NONE, btn: 2'd0, clicks: 4'd0,
                  status: per_pkg::ST_NOTHING, repair: 1'b0, scroll: 1'b0,
                  held: h, pos: pos_ff};
               n = 3'd1;
            end else begin
               for (int i = 0; i < 3; i++) begin
                  if (h[i]) begin
                     h[i] = 1'b0;
                     w.slots[n] = '{cmd: per_pkg::CMD_UP, btn: 2'(i), clicks: 4'd1,
                        status: per_pkg::ST_APPLIED, repair: 1'b0, scroll: 1'b0,
                        held: h, pos: pos_ff};
                     n = n + 3'd1;
                  end
               end
            end
            sample_seen_in = 1'b0; newest_in = '0; bseen_in = '0;
            bseq_in = '{default: '0}; mtime_in = '0; mvalid_in = 1'b0;
         end
         default: begin
            if (r.mode[2] || (r.mode[1] && r.button == 2'd3)) begin
               w.slots[0] = '{cmd: per_pkg::CMD_NONE, btn: 2'd0, clicks: 4'd0,
                  status: per_pkg::ST_NOTHING, repair: 1'b0, scroll: 1'b0,
                  held: h, pos: pos_ff};
               n = 3'd1;
            end else begin
               if (max_ps_ff != '0) begin
                  if ((r.now_ms - wstart_ff) >= WinLimit) begin
                     wstart_in = r.now_ms;
                     cnt = '0;
                  end
                  if (cnt != per_pkg::CountMax) cnt = cnt + 17'd1;
                  wcount_in = cnt;
                  lim = cnt > {1'b0, max_ps_ff};
               end
               if (lim) begin
                  w.slots[0] = '{cmd: per_pkg::CMD_NONE, btn: 2'd0, clicks: 4'd0,
                     status: per_pkg::ST_RATE, repair: 1'b0, scroll: 1'b0,
                     held: h, pos: pos_ff};
                  n = 3'd1;
               end else begin
                  logic stale, doit, rec;
                  stale = 1'b0; doit = 1'b0; rec = 1'b0;
                  mtime_in = r.now_ms; mvalid_in = 1'b1;
                  if (!r.mode[1]) begin
                     stale = sample_seen_ff && r.seq <= newest_ff;
                     if (!stale) begin
                        sample_seen_in = 1'b1; newest_in = r.seq;
                        pos_in = {r.pos_y, r.pos_x};
                        rec = 1'b1;
                     end else if (r.mode[0]) begin
                        w.slots[0] = '{cmd: per_pkg::CMD_SCROLL, btn: 2'd0,
                           clicks: 4'd0, status: per_pkg::ST_STALE_SCROLL,
                           repair: 1'b0, scroll: 1'b1, held: h, pos: pos_ff};
                        n = 3'd1;
                     end else begin
                        w.slots[0] = '{cmd: per_pkg::CMD_NONE, btn: 2'd0,
                           clicks: 4'd0, status: per_pkg::ST_STALE,
                           repair: 1'b0, scroll: 1'b0, held: h, pos: pos_ff};
                        n = 3'd1;
                     end
                  end else begin
                     stale = bseen_ff[r.button[1:0]] && r.seq <= bseq_ff[r.button];
                     if (stale) begin
                        w.slots[0] = '{cmd: per_pkg::CMD_NONE, btn: 2'd0,
                           clicks: 4'd0, status: per_pkg::ST_STALE,
                           repair: 1'b0, scroll: 1'b0, held: h, pos: pos_ff};
                        n = 3'd1;
                     end else begin
                        doit = 1'b1;
                        bseen_in = bseen_ff | bit_m;
                        bseq_in[r.button] = r.seq;
                        if (!sample_seen_ff || r.seq > newest_ff) begin
                           sample_seen_in = 1'b1; newest_in = r.seq;
                        end
                        pos_in = {r.pos_y, r.pos_x};
                     end
                  end
                  if (doit) begin
                     if (!r.mode[0]) begin
                        if ((h & bit_m) == '0) begin
                           h = h | bit_m;
                           w.slots[n] = '{cmd: per_pkg::CMD_DOWN, btn: r.button,
                              clicks: r.clicks, status: per_pkg::ST_APPLIED,
                              repair: 1'b0, scroll: 1'b0, held: h, pos: pos_in};
                        end else begin
                           w.slots[n] = '{cmd: per_pkg::CMD_MOVE, btn: 2'd0,
                              clicks: 4'd0, status: per_pkg::ST_APPLIED,
                              repair: 1'b0, scroll: 1'b0, held: h, pos: pos_in};
                        end
                        n = n + 3'd1;
                     end else begin
                        if ((h & bit_m) == '0) begin
                           h = h | bit_m;
                           w.slots[n] = '{cmd: per_pkg::CMD_DOWN, btn: r.button,
                              clicks: r.clicks, status: per_pkg::ST_APPLIED,
                              repair: 1'b1, scroll: 1'b0, held: h, pos: pos_in};
                           n = n + 3'd1;
                        end
                        h = h & ~bit_m;
                        w.slots[n] = '{cmd: per_pkg::CMD_UP, btn: r.button,
                           clicks: r.clicks, status: per_pkg::ST_APPLIED,
                           repair: 1'b0, scroll: 1'b0, held: h, pos: pos_in};
                        n = n + 3'd1;
                     end
                  end
                  if (rec || doit) begin
                     for (int i = 0; i < 3; i++) begin
                        if (h[i] != r.want_mask[i]) begin
                           h[i] = r.want_mask[i];
                           w.slots[n] = '{cmd: r.want_mask[i] ? per_pkg::CMD_DOWN
                              : per_pkg::CMD_UP, btn: 2'(i), clicks: 4'd1,
                              status: per_pkg::ST_APPLIED, repair: 1'b1,
                              scroll: 1'b0, held: h, pos: pos_in};
                           n = n + 3'd1;
                        end
                     end
                  end
                  if (rec) begin
                     w.slots[n] = '{cmd: per_pkg::CMD_MOVE, btn: 2'd0, clicks: 4'd0,
                        status: per_pkg::ST_APPLIED, repair: 1'b0, scroll: 1'b0,
                        held: h, pos: pos_in};
                     n = n + 3'd1;
                     if (r.mode[0]) begin
                        w.slots[n] = '{cmd: per_pkg::CMD_SCROLL, btn: 2'd0,
                           clicks: 4'd0, status: per_pkg::ST_APPLIED, repair: 1'b0,
                           scroll: 1'b1, held: h, pos: pos_in};
                        n = n + 3'd1;
                     end
                  end
               end
            end
         end
      endcase
      held_in = h;
      w.count = n;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0; sample_seen_ff <= 1'b0; newest_ff <= '0; bseen_ff <= '0;
         bseq_ff <= '{default: '0}; pos_ff <= '0; mtime_ff <= '0; mvalid_ff <= 1'b0;
         wstart_ff <= '0; wcount_ff <= '0;
      end else if (req_valid && !wq_full) begin
         held_ff <= held_in; sample_seen_ff <= sample_seen_in; newest_ff <= newest_in;
         bseen_ff <= bseen_in; bseq_ff <= bseq_in; pos_ff <= pos_in;
         mtime_ff <= mtime_in; mvalid_ff <= mvalid_in;
         wstart_ff <= wstart_in; wcount_ff <= wcount_in;
      end
   end
endmodule
`default_nettype wire

/* rtl/core/per_queue.sv */
`default_nettype none
module per_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire per_pkg::work_type push_data,
   output logic                   full,
   output logic                   not_empty,
   input  wire logic              pop,
   output per_pkg::work_type      head
);
   localparam int unsigned Depth = per_pkg::QueueDepth;
   localparam int unsigned Aw = $clog2(Depth);

   per_pkg::work_type mem_ff [Depth];
   logic [Aw-1:0] wr_ff, rd_ff;
   logic [Aw:0]   cnt_ff;

   assign full = cnt_ff == (Aw+1)'(Depth);
   assign not_empty = cnt_ff != '0;
   assign head = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0; rd_ff <= '0; cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= (wr_ff == Aw'(Depth - 1)) ? '0 : wr_ff + 1'b1;
         if (pop) rd_ff <= (rd_ff == Aw'(Depth - 1)) ? '0 : rd_ff + 1'b1;
         cnt_ff <= cnt_ff + (Aw+1)'(push) - (Aw+1)'(pop);
      end
   end
endmodule
`default_nettype wire

/* rtl/core/per_back.sv */
`default_nettype none
module per_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              wq_not_empty,
   input  wire per_pkg::work_type wq_head,
   output logic                   wq_pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output per_pkg::rsp_type       rsp_payload
);
   logic [2:0] idx_ff;
   logic       vld_ff;
   per_pkg::rsp_type out_ff;
   per_pkg::slot_type s;
   logic       load, is_last;

   assign s = wq_head.slots[idx_ff];
   assign is_last = (idx_ff + 3'd1) == wq_head.count;
   assign load = wq_not_empty && (!vld_ff || !rsp_stall);
   assign wq_pop = load && is_last;
   assign rsp_valid = vld_ff;
   assign rsp_payload = out_ff;

   always_ff @(posedge clock) begin
      if (load) begin
         out_ff.command <= s.cmd;
         out_ff.out_button <= s.btn;
         out_ff.out_x <= s.pos[15:0];
         out_ff.out_y <= s.pos[31:16];
         out_ff.held_now <= s.held;
         out_ff.out_dx <= s.scroll ? wq_head.dx : '0;
         out_ff.out_dy <= s.scroll ? wq_head.dy : '0;
         out_ff.out_clicks <= s.clicks;
         out_ff.status <= s.status;
         out_ff.repair <= s.repair;
         out_ff.last <= is_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0; vld_ff <= 1'b0;
      end else begin
         if (load) idx_ff <= is_last ? '0 : idx_ff + 3'd1;
         if (load) vld_ff <= 1'b1;
         else if (!rsp_stall) vld_ff <= 1'b0;
      end
   end
endmodule
`default_nettype wire

/* rtl/core/pointer_event_reconciler.sv */
// Pointer event reconciler. The front end takes one event per cycle while the
// two-entry queue has room, gates it and expands it into one to five injector
// commands; the back end streams those commands out through an output register,
// one per cycle while rsp_stall is low. The last command of each event carries
// last = 1. No clearing pass after reset.
`default_nettype none
`include "pointer_event_reconciler_assert.svh"
module pointer_event_reconciler #(
   parameter int unsigned WINDOW_MS = per_pkg::WindowMsDefault
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [0:0]       csr_index,
   input  wire logic [15:0]      csr_data,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire per_pkg::req_type req_payload,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output per_pkg::rsp_type      rsp_payload
);
   logic wq_valid, wq_full, wq_ne, wq_pop;
   per_pkg::work_type wq_in, wq_head;

   per_front #(.WINDOW_MS(WINDOW_MS)) u_front (
      .clock, .reset, .csr_valid, .csr_ready, .csr_index, .csr_data,
      .req_valid, .req_stall, .req_payload,
      .wq_valid, .wq_full, .wq_data(wq_in));

   per_queue u_queue (
      .clock, .reset, .push(wq_valid), .push_data(wq_in), .full(wq_full),
      .not_empty(wq_ne), .pop(wq_pop), .head(wq_head));

   per_back u_back (
      .clock, .reset, .wq_not_empty(wq_ne), .wq_head, .wq_pop,
      .rsp_valid, .rsp_stall, .rsp_payload);

   `PER_ASSERT_ALWAYS(a_pop_needs_entry, clock, reset, !wq_pop || wq_ne,
      "queue popped while empty")
   `PER_ASSERT_ALWAYS(a_count_range, clock, reset,
      !wq_ne || (wq_head.count != 3'd0 && wq_head.count <= 3'd5),
      "queued event has bad command count")
   `PER_ASSERT_NEXT(a_pop_is_last, clock, reset, wq_pop, rsp_valid && rsp_payload.last,
      "queue pop without a final response")
endmodule
`default_nettype wire
